@@ sv/cyluv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the cylinder uv-to-point mapper.
package cyluv_pkg;

   localparam int COORD_W    = 32;   // width of every coordinate field
   localparam int FRAC_BITS  = 16;   // fraction bits of the Q16.16 fields
   localparam int REG_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int GUARD_BITS = 8;    // extra low bits kept through the rotator
   localparam int XW         = 42;   // rotator x/y width, signed
   localparam int ZW         = 34;   // rotator angle width, signed
   localparam int SAT_W      = 36;   // input width of the saturation helper
   localparam int ATAN_ENTRIES = 30;

   // 2^32 / (2*pi), rounded: radians in Q16.16 to a 32-bit turn phase
   localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
   // rotator gain compensation 0.607252935 in Q30
   localparam logic [29:0] GAIN_Q30     = 30'd652032874;

   // register indexes of the configuration port
   localparam logic [REG_ADDR_W-1:0] REG_PAT_W   = 3'd0;
   localparam logic [REG_ADDR_W-1:0] REG_PAT_H   = 3'd1;
   localparam logic [REG_ADDR_W-1:0] REG_METRIC  = 3'd2;
   localparam logic [REG_ADDR_W-1:0] REG_RADIUS  = 3'd3;
   localparam logic [REG_ADDR_W-1:0] REG_U_OFF   = 3'd4;
   localparam logic [REG_ADDR_W-1:0] REG_ANGLE   = 3'd5;
   localparam logic [REG_ADDR_W-1:0] REG_Y_SHIFT = 3'd6;
   localparam logic [REG_ADDR_W-1:0] REG_Z_SHIFT = 3'd7;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [29:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   // fields that ride alongside the rotator
   typedef struct packed {
      logic                      ok;
      logic                      flip;
      logic signed [COORD_W-1:0] zres;
   } cyluv_side_type;

   // clamp to the signed coordinate range
   function automatic logic signed [COORD_W-1:0] cyluv_sat(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      logic signed [COORD_W-1:0] res;
      hi = (SAT_W'(1) <<< (COORD_W - 1)) - SAT_W'(1);
      lo = -hi - SAT_W'(1);
      if (v > hi) begin
         res = hi[COORD_W-1:0];
      end else if (v < lo) begin
         res = lo[COORD_W-1:0];
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ sv/cyluv_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module cyluv_cordic #(
   parameter int STAGES = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  logic signed [cyluv_pkg::XW-1:0]  in_x,
   input  logic signed [cyluv_pkg::ZW-1:0]  in_z,
   input  cyluv_pkg::cyluv_side_type        in_side,
   output logic                             out_valid,
   output logic signed [cyluv_pkg::XW-1:0]  out_x,
   output logic signed [cyluv_pkg::XW-1:0]  out_y,
   output cyluv_pkg::cyluv_side_type        out_side
);
   import cyluv_pkg::*;

   logic                 vld_ff  [0:STAGES-1];
   logic signed [XW-1:0] x_ff    [0:STAGES-1];
   logic signed [XW-1:0] y_ff    [0:STAGES-1];
   logic signed [ZW-1:0] z_ff    [0:STAGES-1];
   cyluv_side_type       side_ff [0:STAGES-1];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                 pv;
      logic signed [XW-1:0] px;
      logic signed [XW-1:0] py;
      logic signed [ZW-1:0] pz;
      cyluv_side_type       ps;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic signed [ZW-1:0] ang;

      if (i == 0) begin : g_first
         assign pv = in_valid;
         assign px = in_x;
         assign py = '0;
         assign pz = in_z;
         assign ps = in_side;
      end else begin : g_next
         assign pv = vld_ff[i-1];
         assign px = x_ff[i-1];
         assign py = y_ff[i-1];
         assign pz = z_ff[i-1];
         assign ps = side_ff[i-1];
      end

      assign ang = $signed({{(ZW-30){1'b0}}, ATAN_TURNS[i]});

      // rotate toward zero residual angle
      always_comb begin
         if (!pz[ZW-1]) begin
            x_in = px - (py >>> i);
            y_in = py + (px >>> i);
            z_in = pz - ang;
         end else begin
            x_in = px + (py >>> i);
            y_in = py - (px >>> i);
            z_in = pz + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= ps;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_y     = y_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

@@ sv/cylinder_uv_to_point_top.sv @@
`timescale 1ns / 1ps
// Top level: maps a label texture coordinate (u,v) to a point on a cylinder.
//
// Usage:
//  - req_* carries one (u,v) transaction, rsp_* one (x,y,z) transaction with
//    a valid flag in rsp_tuser; every request gives exactly one response, in order.
//  - Program the eight registers through csr_* while no transaction is in
//    flight; the derived angle and radius terms settle through a product
//    register and then a result register after a write.
//  - Throughput: one transaction per cycle unless rsp_tready stalls. Latency is
//    set by the bit-per-stage dividers (33 stages for u mod width, 32 for the phase
//    quotient, 32 for z run alongside) and by one register stage per CORDIC rotation.
//  - The whole pipeline moves as one: when rsp_tready is low with a response
//    waiting, every stage holds and req_tready drops; nothing is lost or doubled.
//  - Reset (synchronous) empties the pipeline and loads the registers with
//    width = height = 1.0 and every other register zero.
//  - A response with point_ok low (zero height, zero pattern size, or v outside
//    [0, height]) carries zero coordinates.
module cylinder_uv_to_point_top #(
   parameter int TRIG_STAGES = 18
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [63:0]                            req_tdata,  // u_coord, v_coord
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [95:0]                            rsp_tdata,  // out_x, out_y, out_z
   output logic [0:0]                             rsp_tuser,  // point_ok
   input  logic                                   csr_wen,
   input  logic [cyluv_pkg::REG_ADDR_W-1:0]       csr_addr,
   input  logic [cyluv_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cyluv_pkg::*;

   localparam int NC     = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
   localparam int D1_N   = COORD_W + 1;    // steps of |u - u_offset| mod width
   localparam int D2_N   = COORD_W;        // steps of the phase quotient
   localparam int ZD_N   = COORD_W;        // steps of the z quotient
   localparam int I_Z0   = 3;              // first z step (after product and sum)
   localparam int I_RFIX = D1_N + 1;       // remainder sign fix
   localparam int I_ZFIN = I_RFIX + 1;     // z offset and clamp
   localparam int I_PH   = I_RFIX + D2_N + 1;  // phase assembly, feeds the rotator
   localparam int I_ZL   = I_Z0 + ZD_N - 1;    // last z step, lines up with I_RFIX

   // ---------------- configuration registers ----------------
   logic [30:0]        pw_ff, ph_ff, mh_ff, rad_ff;
   logic signed [31:0] uoff_ff, abase_ff, ysh_ff, zsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff    <= 31'd65536;
         ph_ff    <= 31'd65536;
         mh_ff    <= '0;
         rad_ff   <= '0;
         uoff_ff  <= '0;
         abase_ff <= '0;
         ysh_ff   <= '0;
         zsh_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_PAT_W:   pw_ff    <= csr_wdata[30:0];
            REG_PAT_H:   ph_ff    <= csr_wdata[30:0];
            REG_METRIC:  mh_ff    <= csr_wdata[30:0];
            REG_RADIUS:  rad_ff   <= csr_wdata[30:0];
            REG_U_OFF:   uoff_ff  <= csr_wdata;
            REG_ANGLE:   abase_ff <= csr_wdata;
            REG_Y_SHIFT: ysh_ff   <= csr_wdata;
            REG_Z_SHIFT: zsh_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Terms that depend on configuration only: angle base as a phase, and the
   // gain-compensated start vector of the rotator.
   logic signed [62:0]   ang_prod_ff, ang_prod_in;
   logic signed [62:0]   ang_sum;
   logic [31:0]          p2_ff, p2_in;
   logic [60:0]          rad_prod_ff, rad_prod_in;
   logic signed [XW-1:0] x0_ff, x0_in;

   always_comb begin
      ang_prod_in = abase_ff * $signed({1'b0, TURN_PER_RAD});
      ang_sum     = ang_prod_ff + (63'sd1 <<< (FRAC_BITS - 1));
      p2_in       = ang_sum[FRAC_BITS+31:FRAC_BITS];
      rad_prod_in = rad_ff * GAIN_Q30;
      x0_in       = $signed(XW'({rad_prod_ff[60:30], {GUARD_BITS{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      ang_prod_ff <= ang_prod_in;
      p2_ff       <= p2_in;
      rad_prod_ff <= rad_prod_in;
      x0_ff       <= x0_in;
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic out_vld_ff;

   // advance everything unless a response is stuck at the output
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   logic vld_ff [0:I_PH];
   logic ok_ff  [0:I_PH];

   // ---------------- stage 0: input capture ----------------
   logic signed [31:0] u_w, v_w;
   logic signed [32:0] d_w;
   logic               dneg_ff [0:D1_N];
   logic [32:0]        dabs_ff [0:D1_N-1];
   logic [32:0]        zs_ff;
   logic               dneg_in, ok_in;
   logic [32:0]        dabs_in, zs_in;

   always_comb begin
      u_w     = req_tdata[31:0];
      v_w     = req_tdata[63:32];
      d_w     = {u_w[31], u_w} - {uoff_ff[31], uoff_ff};
      dneg_in = d_w[32];
      dabs_in = d_w[32] ? 33'(-d_w) : 33'(d_w);
      ok_in   = (mh_ff != '0) && (pw_ff != '0) && (ph_ff != '0) &&
                !v_w[31] && (v_w[30:0] <= ph_ff);
      // 2v + h, non-negative whenever the point is valid
      zs_in   = {v_w, 1'b0} + {2'b00, ph_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff[0]   <= ok_in;
         dneg_ff[0] <= dneg_in;
         dabs_ff[0] <= dabs_in;
         zs_ff      <= zs_in;
      end
   end

   // carry valid and the ok flag to the rotator
   for (genvar i = 1; i <= I_PH; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ok_ff[i] <= ok_ff[i-1];
         end
      end
   end

   // ---------------- u mod width: one dividend bit per stage ----------------
   logic [30:0] rem1_ff [1:D1_N];

   for (genvar k = 0; k < D1_N; k++) begin : g_mod
      logic [30:0] prev;
      logic [31:0] t, sub;
      logic        ge;
      logic [30:0] rem_in;

      if (k == 0) begin : g_first
         assign prev = '0;
      end else begin : g_next
         assign prev = rem1_ff[k];
      end

      always_comb begin
         t      = {prev, dabs_ff[k][D1_N-1-k]};
         sub    = t - {1'b0, pw_ff};
         ge     = (t >= {1'b0, pw_ff});
         rem_in = ge ? sub[30:0] : t[30:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem1_ff[k+1] <= rem_in;
            dneg_ff[k+1] <= dneg_ff[k];
         end
      end

      if (k < D1_N - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               dabs_ff[k+1] <= dabs_ff[k];
            end
         end
      end
   end

   // ---------------- z quotient ----------------
   // floor(((2v-h)*m + h) / 2h) = floor((m*(2v+h) + h) / 2h) - m
   logic [63:0] zprod_ff, zprod_in, znum_ff, znum_in;
   logic [31:0] zden;
   logic [31:0] zp_ff [I_Z0:I_ZL-1];
   logic [31:0] zq_ff [I_Z0:I_ZL];

   always_comb begin
      zprod_in = mh_ff * zs_ff;
      znum_in  = zprod_ff + 64'(ph_ff);
      zden     = {ph_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zprod_ff <= zprod_in;
         znum_ff  <= znum_in;
      end
   end

   for (genvar k = 0; k < ZD_N; k++) begin : g_zdiv
      logic [31:0] pp, pq;
      logic [32:0] t, sub;
      logic        ge;
      logic [31:0] p_in, q_in;

      if (k == 0) begin : g_first
         assign pp = znum_ff[63:32];
         assign pq = znum_ff[31:0];
      end else begin : g_next
         assign pp = zp_ff[I_Z0+k-1];
         assign pq = zq_ff[I_Z0+k-1];
      end

      always_comb begin
         t    = {pp, pq[31]};
         sub  = t - {1'b0, zden};
         ge   = (t >= {1'b0, zden});
         p_in = ge ? sub[31:0] : t[31:0];
         q_in = {pq[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zq_ff[I_Z0+k] <= q_in;
         end
      end

      if (k < ZD_N - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               zp_ff[I_Z0+k] <= p_in;
            end
         end
      end
   end

   // z offset and clamp, then carry the result to the rotator
   logic signed [COORD_W-1:0] zr_ff [I_ZFIN:I_PH];
   logic signed [34:0]        zsum;
   logic signed [COORD_W-1:0] zr_in;

   always_comb begin
      zsum  = $signed({3'b000, zq_ff[I_ZL]}) - $signed({4'b0000, mh_ff}) +
              $signed({{3{zsh_ff[31]}}, zsh_ff});
      zr_in = cyluv_sat(SAT_W'(zsum));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zr_ff[I_ZFIN] <= zr_in;
      end
   end

   for (genvar i = I_ZFIN + 1; i <= I_PH; i++) begin : g_zcarry
      always_ff @(posedge clock) begin
         if (adv) begin
            zr_ff[i] <= zr_ff[i-1];
         end
      end
   end

   // ---------------- remainder fix and phase quotient ----------------
   logic [30:0] r2_ff [I_RFIX:I_RFIX+D2_N-1];
   logic [31:0] q2_ff [I_RFIX+1:I_RFIX+D2_N];
   logic [30:0] rfix_in;

   // floor modulo: a negative difference with nonzero remainder wraps to w - rem
   always_comb begin
      if (dneg_ff[D1_N] && (rem1_ff[D1_N] != '0)) begin
         rfix_in = pw_ff - rem1_ff[D1_N];
      end else begin
         rfix_in = rem1_ff[D1_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff[I_RFIX] <= rfix_in;
      end
   end

   for (genvar j = 0; j < D2_N; j++) begin : g_frac
      logic [31:0] pq;
      logic [31:0] t, sub;
      logic        ge;
      logic [30:0] r_in;
      logic [31:0] q_in;

      if (j == 0) begin : g_first
         assign pq = '0;
      end else begin : g_next
         assign pq = q2_ff[I_RFIX+j];
      end

      always_comb begin
         t    = {r2_ff[I_RFIX+j], 1'b0};
         sub  = t - {1'b0, pw_ff};
         ge   = (t >= {1'b0, pw_ff});
         r_in = ge ? sub[30:0] : t[30:0];
         q_in = {pq[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q2_ff[I_RFIX+j+1] <= q_in;
         end
      end

      if (j < D2_N - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               r2_ff[I_RFIX+j+1] <= r_in;
            end
         end
      end
   end

   // ---------------- phase assembly ----------------
   logic [31:0]          phase;
   logic                 flip_in, flip_ff;
   logic signed [ZW-1:0] phz_in, phz_ff;

   always_comb begin
      phase   = p2_ff - q2_ff[I_RFIX+D2_N];
      // within a quarter turn of the half turn: rotate by half a turn
      flip_in = phase[31] ^ phase[30];
      phz_in  = flip_in ? ZW'($signed({~phase[31], phase[30:0]})) : ZW'($signed(phase));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flip_ff <= flip_in;
         phz_ff  <= phz_in;
      end
   end

   // ---------------- rotator ----------------
   cyluv_side_type       c_side_in, c_side;
   logic                 c_vld;
   logic signed [XW-1:0] c_x, c_y;

   always_comb begin
      c_side_in.ok   = ok_ff[I_PH];
      c_side_in.flip = flip_ff;
      c_side_in.zres = zr_ff[I_PH];
   end

   cyluv_cordic #(
      .STAGES (NC)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[I_PH]),
      .in_x      (x0_ff),
      .in_z      (phz_ff),
      .in_side   (c_side_in),
      .out_valid (c_vld),
      .out_x     (c_x),
      .out_y     (c_y),
      .out_side  (c_side)
   );

   // ---------------- undo the half turn, round off the guard bits ----------------
   localparam int RW = XW - GUARD_BITS;

   logic                 post_vld_ff;
   cyluv_side_type       post_side_ff;
   logic signed [XW-1:0] xn, yn, xa, ya;
   logic signed [RW-1:0] xr_in, yr_in, xr_ff, yr_ff;

   always_comb begin
      xn    = c_side.flip ? -c_x : c_x;
      yn    = c_side.flip ? -c_y : c_y;
      xa    = xn + (XW'(1) <<< (GUARD_BITS - 1));
      ya    = yn + (XW'(1) <<< (GUARD_BITS - 1));
      xr_in = xa[XW-1:GUARD_BITS];
      yr_in = ya[XW-1:GUARD_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (adv) begin
         post_vld_ff <= c_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         post_side_ff <= c_side;
         xr_ff        <= xr_in;
         yr_ff        <= yr_in;
      end
   end

   // ---------------- output register ----------------
   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic                      ook_ff;

   always_comb begin
      if (post_side_ff.ok) begin
         ox_in = cyluv_sat(SAT_W'(xr_ff));
         oy_in = cyluv_sat(SAT_W'(yr_ff) + SAT_W'(ysh_ff));
         oz_in = post_side_ff.zres;
      end else begin
         // drop the coordinates of an invalid point
         ox_in = '0;
         oy_in = '0;
         oz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= post_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ook_ff <= post_side_ff.ok;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         oz_ff  <= oz_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {oz_ff, oy_ff, ox_ff};
   assign rsp_tuser  = ook_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the cylinder uv-to-point mapper.
module testbench;
   import cyluv_pkg::*;

   localparam int STAGES     = 18;
   localparam int LATENCY    = STAGES + 70;
   localparam int CYCLE_CAP  = 400000;
   localparam longint MASK32 = 64'hFFFFFFFF;

   typedef struct {
      logic              ok;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // u_coord, v_coord
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;   // out_x, out_y, out_z
   logic [0:0]  rsp_tuser;   // point_ok
   logic        csr_wen;
   logic [REG_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow copy of the register file, as the block should hold it
   longint cfg_width, cfg_height, cfg_metric, cfg_radius;
   longint cfg_uoff, cfg_angle, cfg_yshift, cfg_zshift;

   point_type pending_points[$];
   int     error_count;
   int     cycle_count;
   int     burst_left;

   cylinder_uv_to_point_top #(.TRIG_STAGES(STAGES)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Compute the expected point for one (u,v) under the shadow registers.
   function automatic point_type map_uv_to_point(input logic [31:0] u_raw,
                                                 input logic [31:0] v_raw);
      longint    u, v, r, x, y, z, xs, ys, num, den, zq;
      bit [63:0] p1, p2, phase, prod;
      bit        flip;
      point_type res;
      u = longint'(signed'(u_raw));
      v = longint'(signed'(v_raw));
      res = '{ok: 1'b0, x: '0, y: '0, z: '0};
      if (cfg_metric == 0 || cfg_width == 0 || cfg_height == 0 || v < 0 || v > cfg_height) begin
         return res;
      end
      // label part of the phase: fraction of a turn, reversed
      r = (u - cfg_uoff) % cfg_width;
      if (r < 0) begin
         r += cfg_width;
      end
      p1 = (64'd0 - ((64'(r) << 32) / 64'(cfg_width))) & MASK32;
      // angle part: radians to turns, round half up
      prod = 64'(cfg_angle * 64'sd683565276 + 64'sd32768);
      p2 = (prod >> 16) & MASK32;
      phase = (p1 + p2) & MASK32;
      // fold the back half of the circle onto the front half
      flip = ((phase + 64'h40000000) & MASK32) >= 64'h80000000;
      if (flip) begin
         phase ^= 64'h80000000;
      end
      z = longint'(signed'(phase[31:0]));
      x = (cfg_radius * 64'sd652032874) >>> 30;
      x = x * 256;
      y = 0;
      for (int i = 0; i < ((STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES); i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      x = (x + 128) >>> 8;
      y = (y + 128) >>> 8;
      // z: round half up of (v/h - 0.5)*m
      num = (2 * v - cfg_height) * cfg_metric + cfg_height;
      den = 2 * cfg_height;
      zq = num / den;
      if (num % den < 0) begin
         zq -= 1;
      end
      res.ok = 1'b1;
      res.x  = clamp32(x);
      res.y  = clamp32(y + cfg_yshift);
      res.z  = clamp32(zq + cfg_zshift);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Check each response transaction against the oldest expected point.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_points.pop_front();
            if (rsp_tuser[0] !== want.ok)
               report_mismatch("point_ok", rsp_tuser[0], want.ok);
            if (rsp_tdata[31:0] !== want.x)
               report_mismatch("out_x", signed'(rsp_tdata[31:0]), want.x);
            if (rsp_tdata[63:32] !== want.y)
               report_mismatch("out_y", signed'(rsp_tdata[63:32]), want.y);
            if (rsp_tdata[95:64] !== want.z)
               report_mismatch("out_z", signed'(rsp_tdata[95:64]), want.z);
         end
      end
   end

   // Receiver backpressure: switch at random between four patterns.
   int stall_mode;
   int stall_tick;
   always @(negedge clock) begin
      if (stall_tick % 64 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      stall_tick++;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_tready <= (stall_tick % 4 == 0);
         end
         default: begin
            rsp_tready <= (stall_tick % 32 >= 24);
         end
      endcase
   end

   // Write one register and mirror it into the shadow copy.
   task automatic write_reg(input logic [REG_ADDR_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         REG_PAT_W:   cfg_width  = longint'(val[30:0]);
         REG_PAT_H:   cfg_height = longint'(val[30:0]);
         REG_METRIC:  cfg_metric = longint'(val[30:0]);
         REG_RADIUS:  cfg_radius = longint'(val[30:0]);
         REG_U_OFF:   cfg_uoff   = longint'(signed'(val));
         REG_ANGLE:   cfg_angle  = longint'(signed'(val));
         REG_Y_SHIFT: cfg_yshift = longint'(signed'(val));
         default:     cfg_zshift = longint'(signed'(val));
      endcase
   endtask

   // Drain the pipeline, then load all eight registers.
   task automatic load_setup(input logic [31:0] w, h, m, rad, uo, ang, ys, zs);
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      wait (pending_points.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
      // upper bit of the 31-bit registers is random: it must be dropped
      write_reg(REG_PAT_W,   {1'($urandom_range(0, 1)), w[30:0]});
      write_reg(REG_PAT_H,   {1'($urandom_range(0, 1)), h[30:0]});
      write_reg(REG_METRIC,  {1'($urandom_range(0, 1)), m[30:0]});
      write_reg(REG_RADIUS,  {1'($urandom_range(0, 1)), rad[30:0]});
      write_reg(REG_U_OFF,   uo);
      write_reg(REG_ANGLE,   ang);
      write_reg(REG_Y_SHIFT, ys);
      write_reg(REG_Z_SHIFT, zs);
      @(negedge clock);
      csr_wen = 1'b0;
      // let the derived terms settle
      repeat (4) @(negedge clock);
   endtask

   // Send one (u,v) transaction; bursts of random length with random gaps.
   task automatic send_uv(input logic [31:0] u, input logic [31:0] v);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tdata  = {v, u};
      do @(posedge clock); while (!req_tready);
      pending_points.push_back(map_uv_to_point(u, v));
      burst_left--;
   endtask

   function automatic logic [31:0] rand_reg31();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(1, 32'h0000FFFF);
         1:       return $urandom_range(32'h00010000, 32'h03FFFFFF);
         2:       return $urandom_range(32'h7FFF0000, 32'h7FFFFFFF);
         default: return $urandom & 32'h7FFFFFFF;
      endcase
   endfunction

   // v inside [0, height] mostly, sometimes anywhere.
   function automatic logic [31:0] rand_v();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'(cfg_height) + $urandom_range(1, 4);
         2:       return 32'(cfg_height);
         3:       return 32'd0;
         default: return $urandom_range(0, 32'(cfg_height));
      endcase
   endfunction

   // Reset values: metric height zero, every point invalid.
   task automatic test_reset_values();
      send_uv(32'h00000000, 32'h00000000);
      send_uv(32'h00008000, 32'h00010000);
      send_uv($urandom, $urandom);
   endtask

   // Field extremes and boundary cases of v under a typical label.
   task automatic test_directed();
      load_setup(32'd640 << 16, 32'd480 << 16, 32'd10 << 16, 32'd3 << 16,
                 32'd20 << 16, 32'h00008000, 32'hFFFF0000, 32'd5 << 16);
      send_uv(32'h80000000, 32'd0);
      send_uv(32'h7FFFFFFF, 32'd480 << 16);
      send_uv(32'h00000000, 32'd240 << 16);
      send_uv(32'd20 << 16, 32'd1);
      send_uv(32'd180 << 16, 32'd100 << 16);
      send_uv(32'd340 << 16, 32'd300 << 16);
      send_uv(32'd500 << 16, 32'd479 << 16);
      send_uv(32'd660 << 16, 32'd0);
      send_uv(32'hFFFFFFFF, 32'hFFFFFFFF);
      send_uv(32'h00000001, (32'd480 << 16) + 1);
      send_uv(32'h00001234, 32'h7FFFFFFF);
      send_uv(32'hFFFF0000, 32'h80000000);
   endtask

   // Zero pattern size and saturating extremes of the registers.
   task automatic test_register_extremes();
      load_setup(32'd0, 32'd65536, 32'd65536, 32'd65536, 0, 0, 0, 0);
      repeat (3) send_uv($urandom, $urandom_range(0, 65536));
      load_setup(32'd65536, 32'd0, 32'd65536, 32'd65536, 0, 0, 0, 0);
      repeat (3) send_uv($urandom, 32'd0);
      // largest radius, metric and shifts: outputs clamp
      load_setup(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_uv(32'h80000000, 32'h7FFFFFFF);
      send_uv(32'h7FFFFFFF, 32'd0);
      send_uv($urandom, $urandom_range(0, 32'h7FFFFFFF));
      load_setup(32'd1, 32'd1, 32'd1, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000);
      send_uv($urandom, 32'd0);
      send_uv($urandom, 32'd1);
      send_uv($urandom, 32'd2);
   endtask

   // Random points under a series of random register settings.
   task automatic test_random_mapping();
      for (int setup = 0; setup < 6; setup++) begin
         load_setup(rand_reg31(), rand_reg31(),
                    ($urandom_range(0, 7) == 0) ? 32'd0 : rand_reg31(),
                    rand_reg31(), $urandom, $urandom, $urandom, $urandom);
         repeat (85) send_uv($urandom, rand_v());
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wen     = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      error_count = 0;
      cycle_count = 0;
      burst_left  = 0;
      stall_mode  = 0;
      stall_tick  = 0;
      cfg_width = 65536; cfg_height = 65536; cfg_metric = 0; cfg_radius = 0;
      cfg_uoff = 0; cfg_angle = 0; cfg_yshift = 0; cfg_zshift = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed();
      test_register_extremes();
      test_random_mapping();

      // drain: hold off until every response has been seen
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending_points.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
